[hw/rtl/pend_ack_pkg.sv]
package pend_ack_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS = 8;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int ID_W    = 16;
  localparam int ADDR_W  = 16;
  localparam int TIME_W  = 32;
  localparam int RETRY_W = 3;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Register reset values.
  localparam logic [TIME_W-1:0]  TIMEOUT_RST     = 32'd3000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 3'd2;
  localparam logic [ADDR_W-1:0]  BCAST_RST       = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST       = 2'd2;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_REG  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STORED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_HIT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_MISS  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESEND    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BCAST     = 3'd7;

endpackage

[hw/rtl/pending_ack_retry_table_unit.sv]
// A register or ack request scans the slots from slot zero until it finds its slot or
// reaches the last one, then loads its result into the output register; a broadcast
// register needs no scan. A tick visits every slot, then loads its closing result. One request
// at a time; the single slot compare unit visits one slot per cycle while the output is free.
// Reset (rst_n, synchronous, active low): all slots free, registers to their defaults,
// sequencer idle and no result pending; slot contents are left unreset.
module pending_ack_retry_table_unit
  import pend_ack_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // msg_id[15:0], node_addr[31:16], now_ms[63:32]
  input  logic [CMD_W-1:0]       in_tuser,   // command[1:0]

  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slot[2:0], msg_id_res[18:3],
                                             // node_addr_res[34:19], zero[39:35]
  output logic [KIND_W-1:0]      out_tuser,  // kind[2:0]
  output logic                   out_tlast,  // last

  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIME_W-1:0]      cfg_data
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers.
  logic [TIME_W-1:0]  timeout_r;
  logic [RETRY_W-1:0] max_retries_r;
  logic [ADDR_W-1:0]  bcast_r;

  // Slot table: valid bits are reset, the rest is written before it is read.
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [ID_W-1:0]        ent_id_r    [TABLE_SLOTS];
  logic [ADDR_W-1:0]      ent_dest_r  [TABLE_SLOTS];
  logic [TIME_W-1:0]      ent_time_r  [TABLE_SLOTS];
  logic [RETRY_W-1:0]     ent_retry_r [TABLE_SLOTS];

  // Sequencer and the latched request.
  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TIME_W-1:0] now_r;

  // Output register.
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [ID_W-1:0]   out_id_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_last_r;

  // Result to load this cycle.
  logic              push;
  logic [KIND_W-1:0] push_kind;
  logic [ID_W-1:0]   push_id;
  logic [ADDR_W-1:0] push_addr;
  logic              push_last;
  logic              push_slot_en;

  // Slot updates at idx_r.
  logic wr_new;
  logic wr_resend;

  logic              in_fire;
  logic              out_free;
  logic              at_last;
  logic [ID_W-1:0]   cur_id;
  logic [ADDR_W-1:0] cur_dest;
  logic [TIME_W-1:0] cur_time;
  logic [RETRY_W-1:0] cur_retry;
  logic              cur_valid;
  logic [TIME_W-1:0] age;
  logic              aged_out;
  logic              id_match;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // The scan may only take a step when a result produced in this cycle has a place to go.
  assign out_free = !out_valid_r || out_tready;
  assign at_last  = (idx_r == LAST_IDX);

  // The shared slot unit reads, ages and compares one entry per cycle while the output is free.
  assign cur_valid = valid_r[idx_r];
  assign cur_id    = ent_id_r[idx_r];
  assign cur_dest  = ent_dest_r[idx_r];
  assign cur_time  = ent_time_r[idx_r];
  assign cur_retry = ent_retry_r[idx_r];
  assign age       = now_r - cur_time;       // wraps modulo 2^32 by construction
  assign aged_out  = cur_valid && (age > timeout_r);
  assign id_match  = cur_valid && (cur_id == id_r) && (cur_dest == addr_r);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    valid_nxt    = valid_r;
    push         = 1'b0;
    push_kind    = KIND_TICK_DONE;
    push_id      = id_r;
    push_addr    = addr_r;
    push_last    = 1'b1;
    push_slot_en = 1'b0;
    wr_new       = 1'b0;
    wr_resend    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_fire && (in_tuser != CMD_NONE)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          unique case (cmd_r)
            CMD_REG: begin
              // A broadcast destination is never tracked; otherwise take the lowest free slot.
              push = 1'b0;
              if (addr_r == bcast_r) begin
                push      = 1'b1;
                push_kind = KIND_BCAST;
                state_nxt = ST_IDLE;
              end else if (!cur_valid) begin
                push         = 1'b1;
                push_kind    = KIND_STORED;
                push_slot_en = 1'b1;
                wr_new       = 1'b1;
                valid_nxt[idx_r] = 1'b1;
                state_nxt    = ST_IDLE;
              end else if (at_last) begin
                push      = 1'b1;
                push_kind = KIND_FULL;
                state_nxt = ST_IDLE;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            CMD_ACK: begin
              if (id_match) begin
                push         = 1'b1;
                push_kind    = KIND_ACK_HIT;
                push_slot_en = 1'b1;
                valid_nxt[idx_r] = 1'b0;
                state_nxt    = ST_IDLE;
              end else if (at_last) begin
                push      = 1'b1;
                push_kind = KIND_ACK_MISS;
                state_nxt = ST_IDLE;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            CMD_TICK: begin
              // Every slot is visited; aged entries are resent while retries remain, else expire.
              if (aged_out) begin
                push         = 1'b1;
                push_slot_en = 1'b1;
                push_id      = cur_id;
                push_addr    = cur_dest;
                push_last    = 1'b0;
                if (cur_retry < max_retries_r) begin
                  push_kind = KIND_RESEND;
                  wr_resend = 1'b1;
                end else begin
                  push_kind = KIND_EXPIRED;
                  valid_nxt[idx_r] = 1'b0;
                end
              end
              if (at_last) begin
                state_nxt = ST_DONE;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DONE: begin
        // Closing result of a tick.
        if (out_free) begin
          push      = 1'b1;
          push_kind = KIND_TICK_DONE;
          push_id   = '0;
          push_addr = '0;
          push_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
      timeout_r     <= TIMEOUT_RST;
      max_retries_r <= MAX_RETRIES_RST;
      bcast_r       <= BCAST_RST;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIMEOUT:     timeout_r     <= cfg_data;
          CFG_MAX_RETRIES: max_retries_r <= cfg_data[RETRY_W-1:0];
          CFG_BCAST:       bcast_r       <= cfg_data[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Request latch, output payload and slot contents carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_tuser;
      id_r   <= in_tdata[15:0];
      addr_r <= in_tdata[31:16];
      now_r  <= in_tdata[63:32];
    end
    if (push) begin
      out_kind_r <= push_kind;
      out_slot_r <= push_slot_en ? SLOT_W'(idx_r) : '0;
      out_id_r   <= push_id;
      out_addr_r <= push_addr;
      out_last_r <= push_last;
    end
    if (wr_new) begin
      ent_id_r[idx_r]    <= id_r;
      ent_dest_r[idx_r]  <= addr_r;
      ent_time_r[idx_r]  <= now_r;
      ent_retry_r[idx_r] <= '0;
    end else if (wr_resend) begin
      ent_time_r[idx_r]  <= now_r;
      ent_retry_r[idx_r] <= cur_retry + 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_addr_r, out_id_r, out_slot_r};

`ifndef ASSERT_OFF
  // A real request leaves the block busy in the cycle after it is accepted.
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != CMD_NONE)) |=> !in_tready)
    else $error("request accepted while previous one still in progress");

  // Per-entry tick results are never the last one of their request.
  a_tick_entry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((out_tuser == KIND_RESEND) || (out_tuser == KIND_EXPIRED))) |-> !out_tlast)
    else $error("resend or expired result marked last");

  // Every other kind closes its request.
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_RESEND) && (out_tuser != KIND_EXPIRED)) |-> out_tlast)
    else $error("single result not marked last");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  // Leaving the idle state, the scan starts at slot zero.
  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && (state_nxt == ST_SCAN)) |=> (idx_r == '0))
    else $error("scan did not start at slot zero");
`endif

endmodule

[tb/testbench.sv]
// Self-checking bench for the pending acknowledgement table. A directed table of
// requests opens the run, with hand-written results on the rows whose outcome is
// obvious. Several configuration phases of random requests follow, each checked
// against a cycle-free predictor of the slot table kept inside this module.
module testbench;
  import pend_ack_pkg::*;

  localparam int LIMIT_CYCLES    = 500000;
  // A request that yields no result may still be in the scan when the queue runs
  // dry, so the bench waits at least one full scan before touching registers.
  localparam int DRAIN_CYCLES    = TABLE_SLOTS + 6;
  localparam int HOLD_CYCLES     = 200;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 42;
  localparam bit TYPED           = 1'b1;
  localparam bit PREDICTED       = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   msg_id;
    logic [ADDR_W-1:0] node;
    logic              last;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    bit                typed;
    result_t           want;
  } request_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [CMD_W-1:0]       in_tuser    = CMD_NONE;
  logic                   out_tready  = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index   = CFG_TIMEOUT;
  logic [TIME_W-1:0]      cfg_data    = '0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_ready;

  pending_ack_retry_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the registers and of the slot table.
  logic [TIME_W-1:0]  timeout_reg = TIMEOUT_RST;
  logic [RETRY_W-1:0] retry_limit = MAX_RETRIES_RST;
  logic [ADDR_W-1:0]  bcast_addr  = BCAST_RST;
  bit                 slot_busy[TABLE_SLOTS];
  logic [ID_W-1:0]    slot_id[TABLE_SLOTS];
  logic [ADDR_W-1:0]  slot_dest[TABLE_SLOTS];
  logic [TIME_W-1:0]  slot_stamp[TABLE_SLOTS];
  logic [RETRY_W-1:0] slot_tries[TABLE_SLOTS];

  // Results still owed by the block, oldest first.
  result_t     pending_results[$];
  result_t     oldest_res;
  int          err_count     = 0;
  int          results_seen  = 0;
  int          requests_done = 0;
  int          kind_seen[8];
  logic [TIME_W-1:0] wall_ms = '0;

  // Pacing controls shared by the sender and the receiver.
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  bit hold_started = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;
  int unsigned cycle_count = 0;

  function automatic result_t make_result(input logic [KIND_W-1:0] kind,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [ID_W-1:0] id,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic last);
    result_t r;
    r.kind   = kind;
    r.slot   = slot;
    r.msg_id = id;
    r.node   = addr;
    r.last   = last;
    return r;
  endfunction

  // Applies one accepted request to the slot table and lists the results it causes.
  function automatic void model_request(input request_t rq, ref result_t res[$]);
    logic [TIME_W-1:0] age;
    bit done;
    done = 1'b0;
    case (rq.cmd)
      CMD_REG: begin
        if (rq.addr == bcast_addr) begin
          res.push_back(make_result(KIND_BCAST, '0, rq.id, rq.addr, 1'b1));
        end else begin
          // Lowest free slot wins; a full table just reports back.
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!done && !slot_busy[i]) begin
              slot_busy[i]  = 1'b1;
              slot_id[i]    = rq.id;
              slot_dest[i]  = rq.addr;
              slot_stamp[i] = rq.now;
              slot_tries[i] = '0;
              res.push_back(make_result(KIND_STORED, SLOT_W'(i), rq.id, rq.addr, 1'b1));
              done = 1'b1;
            end
          end
          if (!done) res.push_back(make_result(KIND_FULL, '0, rq.id, rq.addr, 1'b1));
        end
      end
      CMD_ACK: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!done && slot_busy[i] && slot_id[i] == rq.id && slot_dest[i] == rq.addr) begin
            slot_busy[i] = 1'b0;
            res.push_back(make_result(KIND_ACK_HIT, SLOT_W'(i), rq.id, rq.addr, 1'b1));
            done = 1'b1;
          end
        end
        if (!done) res.push_back(make_result(KIND_ACK_MISS, '0, rq.id, rq.addr, 1'b1));
      end
      CMD_TICK: begin
        // Age is taken modulo 2^32 so the millisecond counter may wrap.
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          age = rq.now - slot_stamp[i];
          if (slot_busy[i] && age > timeout_reg) begin
            if (slot_tries[i] < retry_limit) begin
              slot_tries[i] = slot_tries[i] + 1'b1;
              slot_stamp[i] = rq.now;
              res.push_back(make_result(KIND_RESEND, SLOT_W'(i), slot_id[i], slot_dest[i],
                                        1'b0));
            end else begin
              slot_busy[i] = 1'b0;
              res.push_back(make_result(KIND_EXPIRED, SLOT_W'(i), slot_id[i], slot_dest[i],
                                        1'b0));
            end
          end
        end
        res.push_back(make_result(KIND_TICK_DONE, '0, '0, '0, 1'b1));
      end
      default: ;  // an undefined command leaves everything alone
    endcase
  endfunction

  function automatic request_t vec(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                   input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now,
                                   input bit typed, input logic [KIND_W-1:0] kind,
                                   input int slot);
    request_t rq;
    rq.cmd   = cmd;
    rq.id    = id;
    rq.addr  = addr;
    rq.now   = now;
    rq.typed = typed;
    rq.want  = (kind == KIND_TICK_DONE) ? make_result(kind, '0, '0, '0, 1'b1)
                                        : make_result(kind, SLOT_W'(slot), id, addr, 1'b1);
    return rq;
  endfunction

  // Mostly well-formed traffic: registrations into a small id/address space so acks
  // find their entries, acks of live entries, and ticks that walk time past the
  // timeout. The rest is unmatched acks and full-range noise, undefined commands too.
  function automatic request_t random_request();
    request_t rq;
    int pick;
    int j;
    int busy[$];
    longint unsigned span;
    rq.typed = PREDICTED;
    rq.want  = '0;
    pick     = $urandom_range(0, 99);
    rq.id    = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0) rq.addr = bcast_addr;
    else if ($urandom_range(0, 5) == 0) rq.addr = ADDR_W'($urandom);
    else rq.addr = ADDR_W'($urandom_range(0, 5));
    rq.now = wall_ms;
    for (int i = 0; i < TABLE_SLOTS; i++) if (slot_busy[i]) busy.push_back(i);
    if (pick < 35) begin
      rq.cmd = CMD_REG;
    end else if (pick < 55) begin
      rq.cmd = CMD_ACK;
      if (busy.size() > 0) begin
        j       = busy[$urandom_range(0, busy.size() - 1)];
        rq.id   = slot_id[j];
        rq.addr = slot_dest[j];
      end
    end else if (pick < 80) begin
      rq.cmd = CMD_TICK;
      if (busy.size() > 0 && $urandom_range(0, 3) == 0) begin
        // Land right on or just past the timeout of a live entry.
        j       = busy[$urandom_range(0, busy.size() - 1)];
        wall_ms = slot_stamp[j] + timeout_reg + TIME_W'($urandom_range(0, 1));
      end else begin
        span = longint'(timeout_reg) + timeout_reg / 2 + 2;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        wall_ms = wall_ms + TIME_W'($urandom_range(0, int'(span)));
      end
      rq.now = wall_ms;
    end else if (pick < 90) begin
      rq.cmd = CMD_ACK;
    end else begin
      rq.cmd  = CMD_W'($urandom_range(0, 3));
      rq.id   = ID_W'($urandom);
      rq.addr = ADDR_W'($urandom);
      rq.now  = $urandom;
    end
    return rq;
  endfunction

  // Offers one request and books its results at the accepting edge. The valid
  // stays high on return so a back-to-back request needs no second assignment.
  task automatic send_request(input request_t rq);
    result_t res[$];
    in_tvalid <= 1'b1;
    in_tuser  <= rq.cmd;
    in_tdata  <= {rq.now, rq.addr, rq.id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_request(rq, res);
    if (rq.typed) begin
      res.delete();
      res.push_back(rq.want);
    end
    foreach (res[k]) pending_results.push_back(res[k]);
    if (rq.cmd != CMD_NONE) requests_done++;
  endtask

  task automatic pace(input bit allow);
    int gap;
    if (allow && idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every booked result has come back and the scan
  // of any result-free request is surely over.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TIMEOUT:     timeout_reg = val;
      CFG_MAX_RETRIES: retry_limit = val[RETRY_W-1:0];
      CFG_BCAST:       bcast_addr  = val[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry junk; the narrow registers must ignore them.
  task automatic program_regs(input logic [TIME_W-1:0] tmo, input logic [RETRY_W-1:0] tries,
                              input logic [ADDR_W-1:0] bcast);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_MAX_RETRIES, {$urandom} & ~TIME_W'(7) | TIME_W'(tries));
    write_reg(CFG_BCAST, {$urandom} & ~TIME_W'(16'hFFFF) | TIME_W'(bcast));
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  // Result checker and receiver pacing. The handshake is judged on the values from
  // before the edge; the ready for the next cycle is then set. A one-off long hold
  // backs the block up into its request channel.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      kind_seen[out_tuser]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d slot %0d", out_tuser,
               out_tdata[SLOT_W-1:0]);
        err_count++;
      end else begin
        oldest_res = pending_results.pop_front();
        check_field("kind", 32'(oldest_res.kind), 32'(out_tuser));
        check_field("slot", 32'(oldest_res.slot), 32'(out_tdata[SLOT_W-1:0]));
        check_field("msg_id_res", 32'(oldest_res.msg_id), 32'(out_tdata[SLOT_W +: ID_W]));
        check_field("node_addr_res", 32'(oldest_res.node),
                    32'(out_tdata[SLOT_W+ID_W +: ADDR_W]));
        check_field("last", 32'(oldest_res.last), 32'(out_tlast));
        check_field("tdata padding", 32'd0,
                    32'(out_tdata[OUT_TDATA_W-1:SLOT_W+ID_W+ADDR_W]));
      end
    end
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    request_t          rows[$];
    request_t          rq;
    int                counted;
    logic [TIME_W-1:0]  ph_timeout[PHASES];
    logic [RETRY_W-1:0] ph_retries[PHASES];
    logic [ADDR_W-1:0]  ph_bcast[PHASES];

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run on the reset values: timeout 3000, two retries and the
    // all-ones broadcast address. The table is filled to the brim, one entry is
    // acked twice, and a series of ticks resends and then drops every entry,
    // including one stamped just before the millisecond counter wraps.
    rows.push_back(vec(CMD_TICK, 16'h0000, 16'h0000, 32'd0, TYPED, KIND_TICK_DONE, 0));
    rows.push_back(vec(CMD_ACK, 16'h0000, 16'h0000, 32'd0, TYPED, KIND_ACK_MISS, 0));
    rows.push_back(vec(CMD_REG, 16'h1234, 16'hFFFF, 32'd0, TYPED, KIND_BCAST, 0));
    rows.push_back(vec(CMD_REG, 16'h0000, 16'h0000, 32'd0, TYPED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF, TYPED, KIND_STORED, 1));
    rows.push_back(vec(CMD_REG, 16'h0001, 16'h0001, 32'd100, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'h0002, 16'h0001, 32'd200, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'h0003, 16'h0002, 32'd300, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'h0004, 16'h0003, 32'd400, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'h0005, 16'h0004, 32'd500, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'h0006, 16'h0005, 32'd600, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'hABCD, 16'h1234, 32'd700, TYPED, KIND_FULL, 0));
    rows.push_back(vec(CMD_ACK, 16'hFFFF, 16'hFFFE, 32'd0, TYPED, KIND_ACK_HIT, 1));
    rows.push_back(vec(CMD_ACK, 16'hFFFF, 16'hFFFE, 32'd0, TYPED, KIND_ACK_MISS, 0));
    rows.push_back(vec(CMD_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_ACK, 16'h0001, 16'h0002, 32'd0, TYPED, KIND_ACK_MISS, 0));
    rows.push_back(vec(CMD_TICK, 16'h0000, 16'h0000, 32'd3000, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_TICK, 16'h0000, 16'h0000, 32'd3001, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_REG, 16'h7777, 16'h0100, 32'hFFFF_FF00, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_TICK, 16'h0000, 16'h0000, 32'd6002, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_TICK, 16'h0000, 16'h0000, 32'd12000, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_TICK, 16'h0000, 16'h0000, 32'd20000, PREDICTED, KIND_STORED, 0));
    rows.push_back(vec(CMD_TICK, 16'h0000, 16'h0000, 32'd20000, TYPED, KIND_TICK_DONE, 0));
    foreach (rows[k]) begin
      send_request(rows[k]);
      pace(1'b1);
    end

    // Register settings per phase. Extremes of every register appear: a zero and a
    // one-millisecond timeout, the largest timeout (nothing ever ages out), no
    // retries and seven, and broadcast at zero, all ones and inside the busy
    // address range.
    ph_timeout = '{32'd0, 32'd1, 32'hFFFF_FFFF, TIME_W'($urandom_range(50, 400)), 32'd1000,
                   TIME_W'($urandom_range(1, 2000)), 32'd3000};
    ph_retries = '{3'd7, 3'd0, 3'd3, RETRY_W'($urandom_range(0, 7)), 3'd1, 3'd2,
                   RETRY_W'($urandom_range(0, 7))};
    ph_bcast   = '{16'h0000, 16'hFFFF, ADDR_W'($urandom), 16'h0003, 16'h00FF, 16'h8000,
                   ADDR_W'($urandom)};

    for (int p = 0; p < PHASES; p++) begin
      settle();
      // The closing phase runs with both sides at full speed.
      if (p == PHASES - 1) idle_on = 1'b0;
      program_regs(ph_timeout[p], ph_retries[p], ph_bcast[p]);
      wall_ms = $urandom;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // Phase two: the receiver holds off for a long stretch while requests keep
        // coming without gaps, so the block has to stall its request channel.
        if (p == 2 && counted == 0) hold_request <= 1'b1;
        // Phase four: the sender stops midway until the block has answered all.
        if (p == 4 && counted == ITEMS_PER_PHASE / 2) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        rq = random_request();
        send_request(rq);
        if (rq.cmd != CMD_NONE) counted++;
        pace(!(p == 2 && counted < 20));
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d results checked over %0d register settings",
             requests_done, results_seen, PHASES + 1);
    $display("run: %0d stored, %0d full, %0d acks matched, %0d resends, %0d expiries",
             kind_seen[KIND_STORED], kind_seen[KIND_FULL], kind_seen[KIND_ACK_HIT],
             kind_seen[KIND_RESEND], kind_seen[KIND_EXPIRED]);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[pending_ack_retry_table_unit.f]
hw/rtl/pend_ack_pkg.sv
hw/rtl/pending_ack_retry_table_unit.sv
tb/testbench.sv
